// ===== sv/tbh_pkg.sv =====
// Shared types and constants for the time bucket byte histogram.
package tbh_pkg;

  localparam int TIME_W  = 64;
  localparam int DUR_W   = 32;
  localparam int MAXB_W  = 9;
  localparam int SIZE_W  = 24;
  localparam int RIDX_W  = 8;
  localparam int BYTES_W = 48;
  localparam int TOTAL_W = 9;
  localparam int DIV_STEPS = 64;
  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic [DUR_W-1:0]   DUR_RESET  = 32'd1000000;
  localparam logic [MAXB_W-1:0]  MAXB_RESET = 9'd256;
  localparam logic [BYTES_W-1:0] BYTES_MAX  = {BYTES_W{1'b1}};

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_ZERO_TIME = 3'd1,
    ST_TOO_OLD   = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_READ_OOR  = 3'd4
  } status_t;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } command_t;

  typedef enum logic {
    REG_DURATION = 1'b0,
    REG_MAX_BUCKETS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                command;
    logic [TIME_W-1:0]   end_time_ns;
    logic [SIZE_W-1:0]   byte_count;
    logic [RIDX_W-1:0]   read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [TIME_W-1:0]   bucket_start_ns;
    logic [BYTES_W-1:0]  bucket_bytes;
    logic [TOTAL_W-1:0]  bucket_total;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    eval;
    logic    fill;
    logic    look;
    logic    issue_k;
    logic    issue_r;
    logic    add;
    logic    rd_done;
    logic    res_set;
    status_t res_code;
    logic    send;
  } tbh_cmd_t;

  typedef struct packed {
    logic is_read;
    logic in_range;
    logic zero_time;
    logic fill_done;
    logic look_ok;
    logic out_free;
  } tbh_stat_t;

endpackage

// ===== sv/tbh_in_if.sv =====
// Input item channel.
interface tbh_in_if import tbh_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tbh_out_if.sv =====
// Result item channel.
interface tbh_out_if import tbh_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tbh_cfg_if.sv =====
// Register write channel.
interface tbh_cfg_if import tbh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             addr;
  logic [DUR_W-1:0] wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

// ===== sv/tbh_ram.sv =====
// Generic single write, single read RAM with registered read data.
module tbh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/tbh_ctrl.sv =====
// Sequencing state machine for the histogram.
module tbh_ctrl import tbh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tbh_stat_t stat,
  output tbh_cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV, S_EVAL, S_FILL, S_LOOK, S_LKCHK,
    S_ISSUE, S_ADD, S_RISSUE, S_RDONE, S_SEND
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.res_code = ST_ADDED;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_read) begin
          if (stat.in_range) begin
            state_next = S_RISSUE;
          end else begin
            cmd.res_set = 1'b1;
            cmd.res_code = ST_READ_OOR;
            state_next = S_SEND;
          end
        end else if (stat.zero_time) begin
          cmd.res_set = 1'b1;
          cmd.res_code = ST_ZERO_TIME;
          state_next = S_SEND;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_FILL;
      end
      S_FILL: begin
        if (stat.fill_done) begin
          state_next = S_LOOK;
        end else begin
          cmd.fill = 1'b1;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        state_next = S_LKCHK;
      end
      S_LKCHK: begin
        if (stat.look_ok) begin
          state_next = S_ISSUE;
        end else begin
          cmd.res_set = 1'b1;
          cmd.res_code = ST_TOO_OLD;
          state_next = S_SEND;
        end
      end
      S_ISSUE: begin
        cmd.issue_k = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_next = S_SEND;
      end
      S_RISSUE: begin
        cmd.issue_r = 1'b1;
        state_next = S_RDONE;
      end
      S_RDONE: begin
        cmd.rd_done = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (stat.out_free) begin
          cmd.send = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CHECK) begin
        cnt <= CNT_W'(DIV_STEPS - 1);
      end else if (state == S_DIV) begin
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule

// ===== sv/tbh_dp.sv =====
// Datapath: divider, window registers, byte store and result register.
module tbh_dp import tbh_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  tbh_cmd_t          cmd,
  output tbh_stat_t         stat,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [DUR_W-1:0]  cfg_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = ((AW > MAXB_W) ? AW : MAXB_W) + 1;
  localparam int LD_W = MAXB_W + DUR_W;
  localparam int RP_W = RIDX_W + DUR_W;

  logic                 cmd_r;
  logic [TIME_W-1:0]    t_r;
  logic [SIZE_W-1:0]    size_r;
  logic [RIDX_W-1:0]    ridx_r;
  logic [TIME_W-1:0]    quo;
  logic [DUR_W-1:0]     rem;
  logic [DUR_W-1:0]     dur;
  logic [MAXB_W-1:0]    maxb;
  logic [MAXB_W-1:0]    held;
  logic [AW-1:0]        ptr;
  logic [TIME_W-1:0]    oldest_q;
  logic [TIME_W-1:0]    oldest_start;
  logic [TIME_W-1:0]    newest_q;
  logic [MAXB_W-1:0]    fill_n;
  logic [MAXB_W-1:0]    kidx;
  logic                 look_ok;
  logic [RP_W-1:0]      rd_prod;
  logic [LD_W-1:0]      lim_dur;
  status_t              res_code;
  logic [TIME_W-1:0]    res_start;
  logic [BYTES_W-1:0]   res_bytes;

  logic [MAXB_W-1:0]    lim;
  logic [DUR_W:0]       trial;
  logic [TIME_W-1:0]    bstart;
  logic [TIME_W-1:0]    gap;
  logic [TIME_W-1:0]    diff;
  logic [AW-1:0]        ptr_inc;
  logic [BYTES_W:0]     sum;
  logic [BYTES_W-1:0]   sum_sat;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [BYTES_W-1:0]   wdata;
  logic [AW-1:0]        raddr;
  logic [BYTES_W-1:0]   rdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [MAXB_W-1:0] pos);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(pos);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign lim = (32'(maxb) > DEPTH) ? MAXB_W'(DEPTH) : maxb;
  assign trial = {rem, quo[TIME_W-1]};
  assign bstart = t_r - TIME_W'(rem);
  assign gap = quo - newest_q;
  assign diff = quo - oldest_q;
  assign ptr_inc = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign sum = {1'b0, rdata} + (BYTES_W + 1)'(size_r);
  assign sum_sat = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];

  assign stat.is_read = (cmd_r == CMD_READ);
  assign stat.in_range = (MAXB_W'(ridx_r) < held);
  assign stat.zero_time = (t_r == '0);
  assign stat.fill_done = (fill_n == '0);
  assign stat.look_ok = look_ok;
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    we = 1'b0;
    waddr = slot(ptr, held);
    wdata = '0;
    if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.add) begin
      we = 1'b1;
      waddr = slot(ptr, kidx);
      wdata = sum_sat;
    end
    raddr = cmd.issue_r ? slot(ptr, MAXB_W'(ridx_r)) : slot(ptr, kidx);
  end

  tbh_ram #(.WIDTH(BYTES_W), .DEPTH(DEPTH)) u_bytes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    lim_dur <= LD_W'(lim - 1'b1) * LD_W'(dur);
    if (cmd.load) begin
      cmd_r <= in_data.command;
      t_r <= in_data.end_time_ns;
      size_r <= in_data.byte_count;
      ridx_r <= in_data.read_index;
      quo <= in_data.end_time_ns;
      rem <= '0;
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, dur}) begin
        rem <= DUR_W'(trial - {1'b0, dur});
        quo <= {quo[TIME_W-2:0], 1'b1};
      end else begin
        rem <= trial[DUR_W-1:0];
        quo <= {quo[TIME_W-2:0], 1'b0};
      end
    end
    if (cmd.look) begin
      look_ok <= (quo >= oldest_q) && (diff < TIME_W'(held));
      kidx <= diff[MAXB_W-1:0];
    end
    if (cmd.issue_r) begin
      rd_prod <= RP_W'(ridx_r) * RP_W'(dur);
    end
    if (cmd.res_set) begin
      res_code <= cmd.res_code;
      res_start <= '0;
      res_bytes <= '0;
    end else if (cmd.add) begin
      res_code <= ST_ADDED;
      res_start <= bstart;
      res_bytes <= sum_sat;
    end else if (cmd.rd_done) begin
      res_code <= ST_READ_OK;
      res_start <= oldest_start + TIME_W'(rd_prod);
      res_bytes <= rdata;
    end
    if (cmd.send) begin
      out_data.status <= res_code;
      out_data.bucket_start_ns <= res_start;
      out_data.bucket_bytes <= res_bytes;
      out_data.bucket_total <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dur <= DUR_RESET;
      maxb <= MAXB_RESET;
      held <= '0;
      ptr <= '0;
      fill_n <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.send) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_DURATION: begin
            if (cfg_wdata != '0 && cfg_wdata != dur) begin
              dur <= cfg_wdata;
              held <= '0;
              ptr <= '0;
            end
          end
          REG_MAX_BUCKETS: begin
            if (cfg_wdata[MAXB_W-1:0] != '0 && cfg_wdata[MAXB_W-1:0] != maxb) begin
              maxb <= cfg_wdata[MAXB_W-1:0];
              held <= '0;
              ptr <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.eval) begin
        if (held == '0) begin
          oldest_q <= quo;
          oldest_start <= bstart;
          newest_q <= quo;
          fill_n <= MAXB_W'(1);
        end else if (quo > newest_q) begin
          newest_q <= quo;
          if (gap >= TIME_W'(lim)) begin
            ptr <= '0;
            held <= '0;
            oldest_q <= quo - TIME_W'(lim - 1'b1);
            oldest_start <= bstart - TIME_W'(lim_dur);
            fill_n <= lim;
          end else begin
            fill_n <= gap[MAXB_W-1:0];
          end
        end else begin
          fill_n <= '0;
        end
      end
      if (cmd.fill) begin
        fill_n <= fill_n - 1'b1;
        if (held >= lim) begin
          ptr <= ptr_inc;
          oldest_q <= oldest_q + 1'b1;
          oldest_start <= oldest_start + TIME_W'(dur);
        end else begin
          held <= held + 1'b1;
        end
      end
    end
  end
endmodule

// ===== sv/time_bucket_byte_histogram_core.sv =====
// Sliding-window byte histogram over time buckets. One transaction is in flight
// at a time. A record with a nonzero time runs the 64-step bit-serial divider
// that aligns the time to the bucket duration, then appends any new buckets to
// the window (up to the window limit) one at a time through the single write
// port of the byte store. Reads and records with zero time skip the divider.
// The next transaction can be taken in the cycle after the result is loaded.
// The result sits in an output register while the next one is taken. Register
// writes are accepted every cycle and clear the window when they change a value.
module time_bucket_byte_histogram_core import tbh_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  tbh_in_if.sink    in,
  tbh_out_if.source out,
  tbh_cfg_if.sink   cfg
);
  tbh_cmd_t  cmd;
  tbh_stat_t stat;

  assign cfg.ready = 1'b1;

  tbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_ready (in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tbh_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in.data),
    .cfg_we    (cfg.valid),
    .cfg_addr  (cfg.addr),
    .cfg_wdata (cfg.wdata),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .out_data  (out.data)
  );
endmodule

// ===== verif/tbh_scoreboard.sv =====
// Checker for the time bucket byte histogram: predicts each result and compares.
`timescale 1ns / 100ps
module tbh_scoreboard import tbh_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  tbh_in_if    in_ch,
  tbh_out_if   out_ch,
  tbh_cfg_if   cfg_ch,
  output int   fails,
  output int   pending
);

  logic [TIME_W-1:0]  win_start [DEPTH];
  logic [BYTES_W-1:0] win_bytes [DEPTH];
  int                 oldest;
  int                 held;
  logic [TIME_W-1:0]  newest;
  logic [DUR_W-1:0]   dur_reg;
  logic [MAXB_W-1:0]  maxb_reg;
  out_item_t          expected_q [$];

  assign pending = expected_q.size();

  function automatic void clear_window();
    oldest = 0;
    held   = 0;
    newest = '0;
  endfunction

  function automatic int slot(int pos);
    return (oldest + pos) % DEPTH;
  endfunction

  function automatic void append_bucket(logic [TIME_W-1:0] start, int limit);
    int s;
    while (held >= limit && held > 0) begin
      oldest = (oldest + 1) % DEPTH;
      held--;
    end
    s = slot(held);
    win_start[s] = start;
    win_bytes[s] = '0;
    held++;
    newest = start;
  endfunction

  function automatic out_item_t predict_bucket(in_item_t it);
    out_item_t         r;
    logic [TIME_W-1:0] dur, b, gap, base, first, k;
    logic [BYTES_W:0]  sum;
    int                limit, s;
    dur   = {32'd0, dur_reg};
    limit = (maxb_reg > DEPTH) ? DEPTH : int'(maxb_reg);
    if (limit == 0) limit = 1;
    r = '0;
    if (it.command == CMD_READ) begin
      if (int'(it.read_index) < held) begin
        s = slot(int'(it.read_index));
        r.status = ST_READ_OK;
        r.bucket_start_ns = win_start[s];
        r.bucket_bytes = win_bytes[s];
      end else begin
        r.status = ST_READ_OOR;
      end
    end else if (it.end_time_ns == '0) begin
      r.status = ST_ZERO_TIME;
    end else begin
      b = (it.end_time_ns / dur) * dur;
      if (held == 0) begin
        append_bucket(b, limit);
      end else if (b > newest) begin
        gap = (b - newest) / dur;
        if (gap >= limit) begin
          base = b - 64'(limit - 1) * dur;
          oldest = 0;
          held = 0;
          for (int j = 0; j < limit; j++) append_bucket(base + 64'(j) * dur, limit);
        end else begin
          base = newest;
          for (int j = 1; j <= int'(gap); j++) append_bucket(base + 64'(j) * dur, limit);
        end
      end
      while (held > limit) begin
        oldest = (oldest + 1) % DEPTH;
        held--;
      end
      first = win_start[slot(0)];
      if (held == 0 || b < first) begin
        r.status = ST_TOO_OLD;
      end else begin
        k = (b - first) / dur;
        if (k < held) begin
          s = slot(int'(k));
          sum = {1'b0, win_bytes[s]} + (BYTES_W + 1)'(it.byte_count);
          if (sum > BYTES_MAX) sum = BYTES_MAX;
          win_bytes[s] = sum[BYTES_W-1:0];
          r.status = ST_ADDED;
          r.bucket_start_ns = win_start[s];
          r.bucket_bytes = sum[BYTES_W-1:0];
        end else begin
          r.status = ST_TOO_OLD;
        end
      end
    end
    r.bucket_total = TOTAL_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    int        nerr;
    nerr = 0;
    if (rst) begin
      dur_reg  <= DUR_RESET;
      maxb_reg <= MAXB_RESET;
      clear_window();
      expected_q.delete();
      fails <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.addr == REG_DURATION) begin
          if (cfg_ch.wdata != '0 && cfg_ch.wdata != dur_reg) begin
            dur_reg = cfg_ch.wdata;
            clear_window();
          end
        end else if (cfg_ch.wdata[MAXB_W-1:0] != '0 &&
                     cfg_ch.wdata[MAXB_W-1:0] != maxb_reg) begin
          maxb_reg = cfg_ch.wdata[MAXB_W-1:0];
          clear_window();
        end
      end
      if (in_ch.valid && in_ch.ready) expected_q.push_back(predict_bucket(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          nerr++;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_ch.data.status);
            nerr++;
          end
          if (out_ch.data.bucket_start_ns !== e.bucket_start_ns) begin
            $error("bucket_start_ns exp %0h got %0h", e.bucket_start_ns,
                   out_ch.data.bucket_start_ns);
            nerr++;
          end
          if (out_ch.data.bucket_bytes !== e.bucket_bytes) begin
            $error("bucket_bytes exp %0h got %0h", e.bucket_bytes, out_ch.data.bucket_bytes);
            nerr++;
          end
          if (out_ch.data.bucket_total !== e.bucket_total) begin
            $error("bucket_total exp %0d got %0d", e.bucket_total, out_ch.data.bucket_total);
            nerr++;
          end
        end
      end
      fails <= fails + nerr;
    end
  end

endmodule

// ===== verif/time_bucket_byte_histogram_core_tb.sv =====
// Testbench top for the time bucket byte histogram: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module time_bucket_byte_histogram_core_tb;
  import tbh_pkg::*;

  localparam int SETTLE = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   quiet_cycles;
  logic no_stall;

  logic [TIME_W-1:0] t_now;
  logic [TIME_W-1:0] dur_now;
  int                lim_now;

  tbh_in_if  in_ch ();
  tbh_out_if out_ch ();
  tbh_cfg_if cfg_ch ();

  time_bucket_byte_histogram_core dut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch)
  );

  tbh_scoreboard chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_DURATION;
    cfg_ch.wdata = '0;
    out_ch.ready = 1'b0;
    no_stall = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = no_stall ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_item(command_t cmd, logic [TIME_W-1:0] t, logic [SIZE_W-1:0] sz,
                           logic [RIDX_W-1:0] ridx);
    int     gap;
    in_item_t it;
    gap = no_stall ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.command = cmd;
    it.end_time_ns = t;
    it.byte_count = sz;
    it.read_index = ridx;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [DUR_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [DUR_W-1:0] d, logic [MAXB_W-1:0] m);
    drain();
    write_reg(REG_DURATION, d);
    write_reg(REG_MAX_BUCKETS, {23'd0, m});
    dur_now = {32'd0, d};
    lim_now = (m > 256) ? 256 : int'(m);
    t_now = {$urandom_range(0, 3), $urandom} + 64'd1;
  endtask

  task automatic random_item();
    int                sel;
    logic [TIME_W-1:0] t;
    logic [SIZE_W-1:0] sz;
    sel = $urandom_range(0, 99);
    sz = (sel % 7 == 0) ? {SIZE_W{1'b1}} : SIZE_W'($urandom);
    if (sel < 25) begin
      send_item(CMD_READ, '0, sz, ($urandom_range(0, 3) == 0) ? RIDX_W'($urandom)
                                   : RIDX_W'($urandom_range(0, lim_now)));
      return;
    end else if (sel < 70) begin
      t = t_now + 64'($urandom_range(0, 2)) * dur_now +
          64'($urandom_range(0, 32'(dur_now - 1)));
    end else if (sel < 80) begin
      t = t_now - 64'($urandom_range(1, lim_now + 2)) * dur_now;
    end else if (sel < 85) begin
      t = '0;
    end else if (sel < 95) begin
      t = t_now + 64'($urandom_range(lim_now - 1, lim_now + 4)) * dur_now;
    end else begin
      t = {$urandom, $urandom};
    end
    if (t > t_now) t_now = t;
    send_item(CMD_RECORD, t, sz, RIDX_W'($urandom));
  endtask

  initial begin
    logic [DUR_W-1:0]  durs [8];
    logic [MAXB_W-1:0] maxbs [8];
    durs  = '{32'd1000000, 32'd1, 32'd7, 32'hFFFFFFFF, 32'd3, 32'd13, 32'd1, 32'd1000};
    maxbs = '{9'd256, 9'd1, 9'd4, 9'd256, 9'd300, 9'd2, 9'd256, 9'd16};
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dur_now = 64'd1000000;
    lim_now = 256;
    send_item(CMD_READ, '0, '0, '0);
    send_item(CMD_READ, '0, '0, 8'hFF);
    send_item(CMD_RECORD, '0, 24'hFFFFFF, '0);
    send_item(CMD_RECORD, 64'd1, '0, 8'hFF);
    send_item(CMD_RECORD, 64'd999999, 24'hFFFFFF, '0);
    send_item(CMD_RECORD, 64'd1000000, 24'd5, '0);
    send_item(CMD_RECORD, 64'd3500000, 24'd9, '0);
    send_item(CMD_READ, '0, '0, 8'd0);
    send_item(CMD_READ, '0, '0, 8'd3);
    send_item(CMD_READ, '0, '0, 8'd4);
    send_item(CMD_RECORD, 64'd900000000, 24'd1, '0);
    send_item(CMD_RECORD, 64'd1000, 24'd1, '0);
    send_item(CMD_READ, '0, '0, 8'd255);
    send_item(CMD_RECORD, {TIME_W{1'b1}}, 24'hFFFFFF, '0);
    send_item(CMD_READ, '0, '0, 8'd0);
    send_item(CMD_READ, '0, '0, 8'd254);
    drain();
    write_reg(REG_DURATION, '0);
    write_reg(REG_MAX_BUCKETS, '0);
    write_reg(REG_DURATION, 32'd1000000);
    send_item(CMD_READ, '0, '0, 8'd0);

    for (int p = 0; p < 8; p++) begin
      configure(durs[p], maxbs[p]);
      for (int i = 0; i < 66; i++) begin
        if (i % 22 == 0) no_stall = ($urandom_range(0, 2) == 0);
        if (i == 33 && p == 2) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        random_item();
      end
    end
    no_stall = 1'b0;
    drain();
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
